// ----- hdl/dnct_pkg.sv -----
// Shared constants for the node cost table.
// No dependencies.
`timescale 1ns / 1ps
package dnct_pkg;
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_FINDMIN = 2'd3;
  localparam logic [31:0] COST_INF = 32'hFFFF_FFFF;
endpackage

// ----- hdl/dnct_cell.sv -----
// One slot of the table: valid bit, key, predecessor, cost and age.
// Depends on dnct_pkg.
`timescale 1ns / 1ps
module dnct_cell import dnct_pkg::*; #(
  parameter int COORD_BITS = 13
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    sh_en,
  input  logic                    sh_valid,
  input  logic [2*COORD_BITS-1:0] sh_key,
  input  logic [2*COORD_BITS-1:0] sh_pred,
  input  logic [31:0]             sh_cost,
  input  logic [31:0]             sh_age,
  input  logic                    wr_en,
  input  logic                    wr_new,
  input  logic                    clr_en,
  input  logic [2*COORD_BITS-1:0] wr_key,
  input  logic [2*COORD_BITS-1:0] wr_pred,
  input  logic [31:0]             wr_cost,
  input  logic [31:0]             wr_age,
  output logic                    valid,
  output logic [2*COORD_BITS-1:0] key,
  output logic [2*COORD_BITS-1:0] pred,
  output logic [31:0]             cost,
  output logic [31:0]             age
);
  logic                    valid_r;
  logic [2*COORD_BITS-1:0] key_r, pred_r;
  logic [31:0]             cost_r, age_r;

  // While the row rotates, each cell takes the contents of its neighbour.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sh_en) begin
      valid_r <= sh_valid;
    end else if (clr_en) begin
      valid_r <= 1'b0;
    end else if (wr_en && wr_new) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sh_en) begin
      key_r  <= sh_key;
      pred_r <= sh_pred;
      cost_r <= sh_cost;
      age_r  <= sh_age;
    end else if (wr_en) begin
      pred_r <= wr_pred;
      cost_r <= wr_cost;
      if (wr_new) begin
        key_r <= wr_key;
        age_r <= wr_age;
      end
    end
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign pred  = pred_r;
  assign cost  = cost_r;
  assign age   = age_r;
endmodule

// ----- hdl/dijkstra_node_cost_table.sv -----
// Node cost table for a shortest-path search, built as a row of slot cells.
// After an input transfer the row rotates one place per cycle through a full
// turn, so every slot passes the head cell once, where it is checked for the
// key, the first free slot or the minimum; the row is then back in place and
// the done state commits the write and loads the result register. The result
// is registered, and the next input is taken once the table is idle again.
// One command is in flight at a time; the commit waits while an earlier
// result is still unread. Depends on dnct_pkg and dnct_cell.
`timescale 1ns / 1ps
module dijkstra_node_cost_table import dnct_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int COORD_BITS  = 13
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // command, node_x, node_y, pred_x, pred_y, cost (from bit 0), zero fill
  input  logic [((2+4*COORD_BITS+32+7)/8)*8-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // found, edge_match, out_cost, out_pred_x, out_pred_y, min_x, min_y,
  // is_empty, overflow (from bit 0), zero fill
  output logic [((37+4*COORD_BITS+7)/8)*8-1:0] out_tdata
);
  localparam int KW = 2 * COORD_BITS;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int OW = ((37 + 4*COORD_BITS + 7) / 8) * 8;
  localparam int OUSED = 37 + 4*COORD_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state_r;
  logic [1:0]  cmd_r;
  logic [KW-1:0] nkey_r, npred_r;
  logic [31:0] ncost_r;
  logic [CW-1:0] ptr_r;
  logic        hit_r, free_r, have_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;
  logic [KW-1:0] hit_pred_r;
  logic [31:0] hit_cost_r;
  logic [31:0] best_cost_r, best_dist_r;
  logic [KW-1:0] best_key_r;
  logic [31:0] stamp_r;
  logic [CW-1:0] count_r;
  logic        ovalid_r;
  logic [OW-1:0] odata_r;

  logic [TABLE_DEPTH-1:0] c_valid, c_wr, c_clr;
  logic [KW-1:0] c_key  [TABLE_DEPTH];
  logic [KW-1:0] c_pred [TABLE_DEPTH];
  logic [31:0]   c_cost [TABLE_DEPTH];
  logic [31:0]   c_age  [TABLE_DEPTH];

  logic wr_new, sh_en;
  assign wr_new = !hit_r;
  assign sh_en  = (state_r == ST_SCAN);

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      localparam int NB = (g + 1) % TABLE_DEPTH;
      dnct_cell #(.COORD_BITS(COORD_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .sh_en(sh_en), .sh_valid(c_valid[NB]),
        .sh_key(c_key[NB]), .sh_pred(c_pred[NB]), .sh_cost(c_cost[NB]),
        .sh_age(c_age[NB]), .wr_en(c_wr[g]), .wr_new(wr_new),
        .clr_en(c_clr[g]), .wr_key(nkey_r), .wr_pred(npred_r),
        .wr_cost(ncost_r), .wr_age(stamp_r), .valid(c_valid[g]),
        .key(c_key[g]), .pred(c_pred[g]), .cost(c_cost[g]), .age(c_age[g])
      );
    end
  endgenerate

  // The head cell holds the slot whose index is the scan pointer.
  logic [IW-1:0] idx;
  assign idx = ptr_r[IW-1:0];
  logic done_ok, do_ins, do_rem;
  assign done_ok = (state_r == ST_DONE) && (!ovalid_r || out_tready);
  assign do_ins  = done_ok && cmd_r == CMD_INSERT && (hit_r || free_r);
  assign do_rem  = done_ok && cmd_r == CMD_REMOVE && hit_r;

  always_comb begin
    c_wr  = '0;
    c_clr = '0;
    if (do_ins) c_wr[hit_r ? hit_idx_r : free_idx_r] = 1'b1;
    if (do_rem) c_clr[hit_idx_r] = 1'b1;
  end

  assign in_tready = (state_r == ST_IDLE);

  // Scan step values for the slot in the head cell.
  logic        s_match, s_cand, s_better;
  logic [31:0] s_dist;
  always_comb begin
    s_match = c_valid[0] && c_key[0] == nkey_r;
    s_dist  = stamp_r - c_age[0];
    s_cand  = c_valid[0] && c_cost[0] != COST_INF;
    s_better = s_cand && (!have_r || c_cost[0] < best_cost_r ||
               (c_cost[0] == best_cost_r && s_dist < best_dist_r));
  end

  // Result assembly.
  logic            r_found, r_edge, r_empty, r_ovf;
  logic [31:0]     r_cost;
  logic [KW-1:0]   r_pred, r_min;
  logic [CW-1:0]   count_nxt;
  always_comb begin
    r_found = 1'b0; r_edge = 1'b0; r_cost = COST_INF;
    r_pred = '1; r_min = '1; r_ovf = 1'b0;
    count_nxt = count_r;
    case (cmd_r)
      CMD_INSERT: begin
        if (!hit_r) begin
          if (free_r) count_nxt = count_r + 1'b1;
          else r_ovf = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (hit_r) count_nxt = count_r - 1'b1;
      end
      CMD_LOOKUP: begin
        if (hit_r) begin
          r_found = 1'b1;
          r_edge  = hit_pred_r == npred_r;
          r_cost  = hit_cost_r;
          r_pred  = hit_pred_r;
        end
      end
      default: begin
        if (have_r) r_min = best_key_r;
      end
    endcase
    r_empty = (count_nxt == '0);
  end

  logic [OUSED-1:0] r_pack;
  assign r_pack = {r_ovf, r_empty, r_min[COORD_BITS-1:0], r_min[KW-1:COORD_BITS],
                   r_pred[COORD_BITS-1:0], r_pred[KW-1:COORD_BITS],
                   r_cost, r_edge, r_found};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      stamp_r  <= '0;
      count_r  <= '0;
    end else begin
      if (done_ok) begin
        ovalid_r <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (ptr_r == CW'(TABLE_DEPTH - 1)) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (done_ok) begin
            state_r  <= ST_IDLE;
            count_r  <= count_nxt;
            if (cmd_r == CMD_INSERT && !hit_r && free_r) stamp_r <= stamp_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Input capture is packed as y in the low half of the key, x above it.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      cmd_r   <= in_tdata[1:0];
      nkey_r  <= {in_tdata[2 +: COORD_BITS], in_tdata[2+COORD_BITS +: COORD_BITS]};
      npred_r <= {in_tdata[2+2*COORD_BITS +: COORD_BITS],
                  in_tdata[2+3*COORD_BITS +: COORD_BITS]};
      ncost_r <= in_tdata[2+4*COORD_BITS +: 32];
      ptr_r   <= '0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
      have_r  <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      ptr_r <= ptr_r + 1'b1;
      if (s_match && !hit_r) begin
        hit_r      <= 1'b1;
        hit_idx_r  <= idx;
        hit_pred_r <= c_pred[0];
        hit_cost_r <= c_cost[0];
      end
      if (!c_valid[0] && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= idx;
      end
      if (s_better) begin
        have_r      <= 1'b1;
        best_cost_r <= c_cost[0];
        best_dist_r <= s_dist;
        best_key_r  <= c_key[0];
      end
    end
    if (done_ok) odata_r <= OW'(r_pack);
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
endmodule
